// ===== src/rmh_pkg.sv =====
// Package with shared types and constants for the running median block.
package rmh_pkg;

  localparam int unsigned SamplePortW = 32;
  localparam int unsigned MedianW     = 33;
  localparam int unsigned CountW      = 11;

  // Shift command given to every cell of one chain.
  typedef struct packed {
    logic push;
    logic pop;
  } rmh_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLACE,
    ST_PUSH2,
    ST_REPORT
  } rmh_state_e;

endpackage

// ===== src/running_median_two_heaps.sv =====
// Top level of the running median block built from two sorted cell chains.
//
// Usage: drive sample_i and raise start; the sample transfers at a rising edge
// where start is high and busy is low. busy stays high until the result has
// been shown. The result (median_doubled_o, element_count_o, dropped_o) is on
// its ports for exactly one cycle, marked by done_o, and transfers at the edge
// that ends that cycle; the receiver cannot stall it.
// The lower half sits in a descending chain and the upper half in an ascending
// chain, so both tops are always in the first cell of their chain. A push or a
// pop shifts all cells of a chain together.
// After the transfer the controller enters ST_PLACE and then ST_REPORT, where done_o
// is high, when the sample goes straight into one chain; when a top must first
// cross to the other chain it passes through ST_PUSH2 in between, since the lower
// or upper chain then shifts twice in a row. A new sample can transfer in the cycle
// after done_o, so the block never takes a sample before the last one is through.
// median_doubled_o is twice the median, exact. When both chains are full the
// sample is discarded and dropped_o is set.
// Reset clears both fill counts and returns the controller to idle; the
// stored values themselves are not cleared.
module running_median_two_heaps #(
  parameter int unsigned HALF_CAPACITY = 512,
  parameter int unsigned SAMPLE_WIDTH  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [rmh_pkg::SamplePortW-1:0] sample_i,
  output logic                                   done_o,
  output logic signed [rmh_pkg::MedianW-1:0]     median_doubled_o,
  output logic        [rmh_pkg::CountW-1:0]      element_count_o,
  output logic                                   dropped_o
);
  import rmh_pkg::*;

  localparam int unsigned SzW  = $clog2(HALF_CAPACITY + 1);
  localparam int unsigned TotW = SzW + 1;
  localparam logic [TotW-1:0] FullCount = TotW'(2 * HALF_CAPACITY);

  rmh_state_e state_q, state_d;
  logic [SAMPLE_WIDTH-1:0] x_q;
  logic                    drop_q, drop_d;
  logic                    second_lo_q, second_lo_d;

  rmh_cmd_t                lo_cmd, up_cmd;
  logic [SAMPLE_WIDTH-1:0] lo_x, up_x;
  logic [SAMPLE_WIDTH-1:0] lo_top, up_top;
  logic [SzW-1:0]          lo_size, up_size;
  logic [TotW-1:0]         total;
  logic                    accept;
  logic signed [SAMPLE_WIDTH:0] med;

  assign accept = start && (state_q == ST_IDLE);
  assign total  = TotW'(lo_size) + TotW'(up_size);

  rmh_chain #(
    .DEPTH  (HALF_CAPACITY),
    .WIDTH  (SAMPLE_WIDTH),
    .IS_MAX (1'b1)
  ) u_lower (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lo_cmd),
    .x_i    (lo_x),
    .top_o  (lo_top),
    .size_o (lo_size)
  );

  rmh_chain #(
    .DEPTH  (HALF_CAPACITY),
    .WIDTH  (SAMPLE_WIDTH),
    .IS_MAX (1'b0)
  ) u_upper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (up_cmd),
    .x_i    (up_x),
    .top_o  (up_top),
    .size_o (up_size)
  );

  always_comb begin
    state_d     = state_q;
    drop_d      = drop_q;
    second_lo_d = second_lo_q;
    lo_cmd      = '0;
    up_cmd      = '0;
    lo_x        = x_q;
    up_x        = x_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          drop_d  = 1'b0;
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        state_d = ST_REPORT;
        if (total == FullCount) begin
          drop_d = 1'b1;
        end else if (lo_size == up_size) begin
          if ((lo_size == '0) || !($signed(lo_top) < $signed(x_q))) begin
            lo_cmd.push = 1'b1;
          end else begin
            up_cmd.push = 1'b1;
          end
        end else if (lo_size > up_size) begin
          if (!($signed(x_q) < $signed(lo_top))) begin
            up_cmd.push = 1'b1;
          end else begin
            // The lower top crosses over; the sample follows into the lower chain.
            lo_cmd.pop  = 1'b1;
            up_cmd.push = 1'b1;
            up_x        = lo_top;
            second_lo_d = 1'b1;
            state_d     = ST_PUSH2;
          end
        end else begin
          if ($signed(x_q) < $signed(up_top)) begin
            lo_cmd.push = 1'b1;
          end else begin
            up_cmd.pop  = 1'b1;
            lo_cmd.push = 1'b1;
            lo_x        = up_top;
            second_lo_d = 1'b0;
            state_d     = ST_PUSH2;
          end
        end
      end
      ST_PUSH2: begin
        if (second_lo_q) begin
          lo_cmd.push = 1'b1;
        end else begin
          up_cmd.push = 1'b1;
        end
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drop_q      <= 1'b0;
      second_lo_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drop_q      <= drop_d;
      second_lo_q <= second_lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_i[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    if (total == '0) begin
      med = '0;
    end else if (lo_size == up_size) begin
      med = $signed({lo_top[SAMPLE_WIDTH-1], lo_top}) + $signed({up_top[SAMPLE_WIDTH-1], up_top});
    end else if (lo_size > up_size) begin
      med = $signed({lo_top, 1'b0});
    end else begin
      med = $signed({up_top, 1'b0});
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_REPORT);
  assign median_doubled_o = MedianW'(med);
  assign element_count_o  = CountW'(total);
  assign dropped_o        = drop_q;

endmodule

// ===== src/rmh_cell.sv =====
// One cell of a sorted chain: holds one value and shifts with its neighbors.
module rmh_cell #(
  parameter int unsigned WIDTH  = 32,
  parameter bit          IS_MAX = 1'b1
) (
  input  logic               clk_i,
  input  rmh_pkg::rmh_cmd_t  cmd_i,
  input  logic               occ_i,
  input  logic [WIDTH-1:0]   x_i,
  input  logic [WIDTH-1:0]   prev_i,
  input  logic               prev_ins_i,
  input  logic [WIDTH-1:0]   next_i,
  output logic [WIDTH-1:0]   val_o,
  output logic               ins_o
);
  import rmh_pkg::*;

  logic [WIDTH-1:0] val_q, val_d;
  logic             above;

  // The new value belongs in front of this cell when it ranks strictly higher.
  assign above = IS_MAX ? ($signed(x_i) > $signed(val_q)) : ($signed(x_i) < $signed(val_q));
  assign ins_o = ~occ_i | above;

  always_comb begin
    val_d = val_q;
    if (cmd_i.pop) begin
      val_d = next_i;
    end else if (cmd_i.push && ins_o) begin
      val_d = prev_ins_i ? prev_i : x_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== src/rmh_chain.sv =====
// Sorted chain of cells acting as a priority queue with its top in the first cell.
module rmh_chain #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned WIDTH  = 32,
  parameter bit          IS_MAX = 1'b1,
  localparam int unsigned SzW   = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmh_pkg::rmh_cmd_t  cmd_i,
  input  logic [WIDTH-1:0]   x_i,
  output logic [WIDTH-1:0]   top_o,
  output logic [SzW-1:0]     size_o
);
  import rmh_pkg::*;

  logic [DEPTH-1:0][WIDTH-1:0] vals;
  logic [DEPTH-1:0]            ins;
  logic [SzW-1:0]              size_q, size_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] prev_v;
    logic [WIDTH-1:0] next_v;
    logic             prev_ins;
    logic             occ;

    assign occ = SzW'(i) < size_q;
    if (i == 0) begin : g_first
      assign prev_v   = x_i;
      assign prev_ins = 1'b0;
    end else begin : g_rest
      assign prev_v   = vals[i-1];
      assign prev_ins = ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_inner
      assign next_v = vals[i+1];
    end

    rmh_cell #(
      .WIDTH  (WIDTH),
      .IS_MAX (IS_MAX)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .occ_i      (occ),
      .x_i        (x_i),
      .prev_i     (prev_v),
      .prev_ins_i (prev_ins),
      .next_i     (next_v),
      .val_o      (vals[i]),
      .ins_o      (ins[i])
    );
  end

  always_comb begin
    size_d = size_q;
    if (cmd_i.pop) begin
      size_d = size_q - SzW'(1);
    end else if (cmd_i.push) begin
      size_d = size_q + SzW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else begin
      size_q <= size_d;
    end
  end

  assign top_o  = vals[0];
  assign size_o = size_q;

endmodule
